### rtl/two_set_algebra_engine_defines.svh
// Assertion shorthands used by the checker file of the set engine.
`ifndef TWO_SET_ALGEBRA_ENGINE_DEFINES_SVH
`define TWO_SET_ALGEBRA_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSAE_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSAE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tsae_pkg.sv
`default_nettype none

package tsae_pkg;

    // Sizing
    localparam int SET_DEPTH = 32;
    localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int COUNT_W   = 6;
    localparam int OP_W      = 4;
    localparam int DATA_W    = 32;

    typedef logic [OP_W-1:0]                   t_op;
    typedef logic [COUNT_W-1:0]                t_count;
    typedef logic signed [DATA_W-1:0]          t_word;
    typedef logic [SET_DEPTH-1:0][DATA_W-1:0]  t_set;

    // Opcodes
    localparam t_op OP_INS_A      = 4'd0;
    localparam t_op OP_INS_B      = 4'd1;
    localparam t_op OP_CLEAR      = 4'd2;
    localparam t_op OP_IN_A       = 4'd3;
    localparam t_op OP_IN_B       = 4'd4;
    localparam t_op OP_UNION      = 4'd5;
    localparam t_op OP_INTER      = 4'd6;
    localparam t_op OP_A_MINUS_B  = 4'd7;
    localparam t_op OP_SYMDIFF    = 4'd8;
    localparam t_op OP_SUBSET     = 4'd9;
    localparam t_op OP_EQUAL      = 4'd10;

    // How one walk over a source set behaves
    typedef struct packed {
        logic src_b;     // walk B (test against A), else walk A (test against B)
        logic desc;      // newest entry first
        logic emit_all;  // every source entry qualifies
        logic want_in;   // qualify when the entry is (1) or is not (0) in the other set
        logic is_check;  // qualifying entry marks a failed subset test
    } t_pass_cfg;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic fin;
        logic pass;
        t_op  op;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pass_done;
        logic out_free;
    } t_dp_stat;

    // Opcodes that walk the stored sets
    function automatic logic is_walk_op(t_op op);
        return (op == OP_UNION) || (op == OP_INTER) || (op == OP_A_MINUS_B) ||
               (op == OP_SYMDIFF) || (op == OP_SUBSET) || (op == OP_EQUAL);
    endfunction

    function automatic logic two_pass(t_op op);
        return (op == OP_UNION) || (op == OP_SYMDIFF) || (op == OP_EQUAL);
    endfunction

    function automatic t_pass_cfg pass_cfg(t_op op, logic pass);
        t_pass_cfg c;
        c = '0;
        unique case (op)
            OP_UNION: begin
                c.src_b    = !pass;
                c.emit_all = pass;
            end
            OP_INTER:     c.want_in = 1'b1;
            OP_A_MINUS_B: c.want_in = 1'b0;
            OP_SYMDIFF: begin
                c.src_b = pass;
                c.desc  = 1'b1;
            end
            OP_SUBSET:    c.is_check = 1'b1;
            OP_EQUAL: begin
                c.src_b    = pass;
                c.is_check = 1'b1;
            end
            default:      c = '0;
        endcase
        return c;
    endfunction

    // Parallel compare of a key against the live entries of one set
    function automatic logic member(t_set vals, t_count size, t_word key);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SET_DEPTH; i++) begin
            if ((COUNT_W'(i) < size) && (vals[i] == key)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

### rtl/tsae_ctrl.sv
`default_nettype none

module tsae_ctrl import tsae_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_op      i_opcode,
    input  wire t_dp_stat i_stat,
    output logic          o_in_stall,
    output t_dp_cmd       o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_PASS  = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    logic [1:0] r_state, n_state;
    t_op        r_op, n_op;
    logic       r_pass, n_pass;

    // Next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_pass  = r_pass;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_opcode;
                    n_pass  = 1'b0;
                    n_state = is_walk_op(i_opcode) ? ST_LOAD : ST_FINAL;
                end
            end
            ST_LOAD: n_state = ST_PASS;
            ST_PASS: begin
                if (i_stat.pass_done) begin
                    if (!r_pass && two_pass(r_op)) begin
                        n_pass  = 1'b1;
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_CLEAR;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_pass  <= n_pass;
        end
    end

    // Commands
    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_cmd.accept = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.load   = (r_state == ST_LOAD);
    assign o_cmd.step   = (r_state == ST_PASS);
    assign o_cmd.fin    = (r_state == ST_FINAL);
    assign o_cmd.pass   = r_pass;
    assign o_cmd.op     = r_op;

endmodule

`default_nettype wire

### rtl/tsae_dp.sv
`default_nettype none

module tsae_dp import tsae_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    input  wire t_word   i_operand_value,
    input  wire logic    i_out_stall,
    output t_dp_stat     o_stat,
    output logic         o_out_valid,
    output logic         o_has_value,
    output t_word        o_result_value,
    output logic         o_last,
    output logic         o_flag,
    output t_count       o_count_a,
    output t_count       o_count_b,
    output logic         o_full_error
);

    // Set storage and sizes
    t_set   r_set_a, r_set_b;
    t_count r_size_a, n_size_a, r_size_b, n_size_b;
    t_word  r_operand, n_operand;

    // Walk state
    t_count r_cnt, n_cnt;
    t_word  r_held, n_held;
    logic   r_held_v, n_held_v;
    logic   r_fail, n_fail;

    // Output beat register
    logic   r_ov, n_ov;
    logic   r_o_has, n_o_has;
    t_word  r_o_val, n_o_val;
    logic   r_o_last, n_o_last;
    logic   r_o_flag, n_o_flag;
    t_count r_o_ca, n_o_ca;
    t_count r_o_cb, n_o_cb;
    logic   r_o_ferr, n_o_ferr;

    t_pass_cfg        cfg;
    t_count           size_src;
    t_count           idx_full;
    logic [IDX_W-1:0] idx;
    t_word            elem;
    t_word            key;
    logic             hit_a, hit_b, hit, qual;
    logic             out_free, pass_done, walking, push, advance;
    logic             wr_a, wr_b;

    // Element select and membership test
    always_comb begin
        cfg      = pass_cfg(i_cmd.op, i_cmd.pass);
        size_src = cfg.src_b ? r_size_b : r_size_a;
        idx_full = cfg.desc ? (r_cnt - 1'b1) : (size_src - r_cnt);
        idx      = idx_full[IDX_W-1:0];
        elem     = cfg.src_b ? t_word'(r_set_b[idx]) : t_word'(r_set_a[idx]);
        key      = i_cmd.fin ? r_operand : elem;
        hit_a    = member(r_set_a, r_size_a, key);
        hit_b    = member(r_set_b, r_size_b, key);
        hit      = cfg.src_b ? hit_a : hit_b;
        qual     = cfg.emit_all | (hit == cfg.want_in);
    end

    assign out_free  = !r_ov || !i_out_stall;
    assign pass_done = (r_cnt == '0);
    assign walking   = i_cmd.step && !pass_done;
    // a new qualifying element pushes the held one out as a non-final beat
    assign push      = walking && qual && !cfg.is_check && r_held_v;
    assign advance   = walking && (!push || out_free);

    // Next values
    always_comb begin
        n_size_a  = r_size_a;
        n_size_b  = r_size_b;
        n_operand = r_operand;
        n_cnt     = r_cnt;
        n_held    = r_held;
        n_held_v  = r_held_v;
        n_fail    = r_fail;
        n_ov      = r_ov;
        n_o_has   = r_o_has;
        n_o_val   = r_o_val;
        n_o_last  = r_o_last;
        n_o_flag  = r_o_flag;
        n_o_ca    = r_o_ca;
        n_o_cb    = r_o_cb;
        n_o_ferr  = r_o_ferr;
        wr_a      = 1'b0;
        wr_b      = 1'b0;

        if (i_cmd.accept) begin
            n_operand = i_operand_value;
        end
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        // start of a walk
        if (i_cmd.load) begin
            n_cnt = size_src;
            if (!i_cmd.pass) begin
                n_held_v = 1'b0;
                n_fail   = 1'b0;
            end
        end

        // one source entry per cycle, unless a push waits for the output register
        if (advance) begin
            n_cnt = r_cnt - 1'b1;
            if (qual) begin
                if (cfg.is_check) begin
                    n_fail = 1'b1;
                end else begin
                    n_held   = elem;
                    n_held_v = 1'b1;
                end
            end
            if (push) begin
                n_ov     = 1'b1;
                n_o_has  = 1'b1;
                n_o_val  = r_held;
                n_o_last = 1'b0;
                n_o_flag = 1'b0;
                n_o_ca   = r_size_a;
                n_o_cb   = r_size_b;
                n_o_ferr = 1'b0;
            end
        end

        // closing beat of every opcode
        if (i_cmd.fin && out_free) begin
            n_ov     = 1'b1;
            n_o_has  = 1'b0;
            n_o_val  = '0;
            n_o_last = 1'b1;
            n_o_flag = 1'b0;
            n_o_ferr = 1'b0;
            unique case (i_cmd.op)
                OP_INS_A: begin
                    if (!hit_a) begin
                        if (r_size_a >= COUNT_W'(SET_DEPTH)) begin
                            n_o_ferr = 1'b1;
                        end else begin
                            wr_a     = 1'b1;
                            n_size_a = r_size_a + 1'b1;
                        end
                    end
                end
                OP_INS_B: begin
                    if (!hit_b) begin
                        if (r_size_b >= COUNT_W'(SET_DEPTH)) begin
                            n_o_ferr = 1'b1;
                        end else begin
                            wr_b     = 1'b1;
                            n_size_b = r_size_b + 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    n_size_a = '0;
                    n_size_b = '0;
                end
                OP_IN_A: n_o_flag = hit_a;
                OP_IN_B: n_o_flag = hit_b;
                OP_UNION, OP_INTER, OP_A_MINUS_B, OP_SYMDIFF: begin
                    // held element is the final one; none means empty result
                    if (r_held_v) begin
                        n_o_has = 1'b1;
                        n_o_val = r_held;
                    end
                    n_held_v = 1'b0;
                end
                OP_SUBSET, OP_EQUAL: n_o_flag = !r_fail;
                default: n_o_flag = 1'b0;
            endcase
            n_o_ca = n_size_a;
            n_o_cb = n_size_b;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_a <= '0;
            r_size_b <= '0;
            r_cnt    <= '0;
            r_held_v <= 1'b0;
            r_fail   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_size_a <= n_size_a;
            r_size_b <= n_size_b;
            r_cnt    <= n_cnt;
            r_held_v <= n_held_v;
            r_fail   <= n_fail;
            r_ov     <= n_ov;
        end
    end

    // Payload registers and set entries
    always_ff @(posedge i_clk) begin
        r_operand <= n_operand;
        r_held    <= n_held;
        r_o_has   <= n_o_has;
        r_o_val   <= n_o_val;
        r_o_last  <= n_o_last;
        r_o_flag  <= n_o_flag;
        r_o_ca    <= n_o_ca;
        r_o_cb    <= n_o_cb;
        r_o_ferr  <= n_o_ferr;
        if (wr_a) begin
            r_set_a[r_size_a[IDX_W-1:0]] <= r_operand;
        end
        if (wr_b) begin
            r_set_b[r_size_b[IDX_W-1:0]] <= r_operand;
        end
    end

    assign o_stat.pass_done = pass_done;
    assign o_stat.out_free  = out_free;
    assign o_out_valid      = r_ov;
    assign o_has_value      = r_o_has;
    assign o_result_value   = r_o_val;
    assign o_last           = r_o_last;
    assign o_flag           = r_o_flag;
    assign o_count_a        = r_o_ca;
    assign o_count_b        = r_o_cb;
    assign o_full_error     = r_o_ferr;

endmodule

`default_nettype wire

### rtl/two_set_algebra_engine.sv
// Two-set algebra engine: keeps sets A and B of up to 32 distinct 32-bit values.
// Input channel (i_in_valid / o_in_stall) carries an opcode and an operand; a
// beat is taken while the engine is idle, one opcode at a time.
// Output channel (o_out_valid / i_out_stall) returns result beats; the last
// beat of each opcode has o_last set. Set results come one element per beat,
// an empty set result is one beat with o_has_value low.
// Insert, clear, membership and no-op opcodes go from acceptance straight to
// the final state, which puts their beat in the output register; the next
// opcode can be taken once the engine is back in idle.
// Set walks test one stored entry per cycle against all entries of the other
// set in parallel, unless the walk pauses for the output register (below); each
// walk has a load state and a pass state over its entries, and union, symmetric
// difference and equality walk both sets. Elements leave one behind the walk.
// A stalled receiver holds the output register; a walk pauses when the next
// element needs that register, and the input stays stalled until the final
// beat is in the output register.
// Reset (synchronous, active low) empties both sets and drops any pending beat.
`default_nettype none

module two_set_algebra_engine import tsae_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_op  i_opcode,
    input  wire t_word i_operand_value,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output logic      o_has_value,
    output t_word     o_result_value,
    output logic      o_last,
    output logic      o_flag,
    output t_count    o_count_a,
    output t_count    o_count_b,
    output logic      o_full_error
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    tsae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Set storage, compare and output register
    tsae_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operand_value (i_operand_value),
        .i_out_stall     (i_out_stall),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_has_value     (o_has_value),
        .o_result_value  (o_result_value),
        .o_last          (o_last),
        .o_flag          (o_flag),
        .o_count_a       (o_count_a),
        .o_count_b       (o_count_b),
        .o_full_error    (o_full_error)
    );

endmodule

`default_nettype wire

### rtl/tsae_chk.sv
`include "two_set_algebra_engine_defines.svh"
`default_nettype none

module tsae_chk import tsae_pkg::*; (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   o_out_valid,
    input wire logic   i_out_stall,
    input wire logic   o_has_value,
    input wire t_word  o_result_value,
    input wire logic   o_last,
    input wire logic   o_flag,
    input wire t_count o_count_a,
    input wire t_count o_count_b,
    input wire logic   o_full_error
);

    // stalled output beat holds
    `TSAE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_result_value) && $stable(o_last) && $stable(o_has_value), "stalled output beat changed")

    // a beat without an element carries zero
    `TSAE_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_has_value, o_result_value == '0, "value present without has_value")

    // element beats carry no answer flag or error, and an error beat ends its opcode
    `TSAE_ASSERT_NOW(a_kind_excl, i_clk, i_rst_n, o_out_valid, !(o_has_value && (o_flag || o_full_error)) && (!o_full_error || o_last), "mixed beat kinds")

    // set sizes never exceed the depth
    `TSAE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_out_valid, (o_count_a <= COUNT_W'(SET_DEPTH)) && (o_count_b <= COUNT_W'(SET_DEPTH)), "set size beyond depth")

endmodule

bind two_set_algebra_engine tsae_chk u_tsae_chk (.*);

`default_nettype wire
